// ----- rtl/core/motor_run_supervisor_fsm_assert.svh -----
// assertion macros, sampled on clk_i, off during reset
`ifndef MOTOR_RUN_SUPERVISOR_FSM_ASSERT_SVH
`define MOTOR_RUN_SUPERVISOR_FSM_ASSERT_SVH

// same-cycle property
`define MRS_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle property
`define MRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/mrs_pkg.sv -----
package mrs_pkg;

  localparam int FreqW = 16;
  localparam int CfgW = 16;
  localparam int TimerBitsDefault = 16;
  localparam int StateCodeW = 3;

  localparam logic [CfgW-1:0] MinSafeFreqRst = 16'd0;
  localparam logic [CfgW-1:0] MinFreeFreqRst = 16'd65535;
  localparam logic [CfgW-1:0] StartTimeoutRst = 16'd100;
  localparam logic [CfgW-1:0] FinishTimeoutRst = 16'd100;

  typedef enum logic [1:0] {
    CFG_MIN_SAFE_FREQ  = 2'd0,
    CFG_MIN_FREE_FREQ  = 2'd1,
    CFG_START_TIMEOUT  = 2'd2,
    CFG_FINISH_TIMEOUT = 2'd3
  } cfg_idx_e;

  typedef enum logic [6:0] {
    ST_STOPPED     = 7'b0000001,
    ST_AUTO_START  = 7'b0000010,
    ST_AUTO        = 7'b0000100,
    ST_AUTO_FINISH = 7'b0001000,
    ST_MAN_START   = 7'b0010000,
    ST_MAN         = 7'b0100000,
    ST_CLEARING    = 7'b1000000
  } run_state_e;

  localparam logic [StateCodeW-1:0] RsStopped     = 3'd0;
  localparam logic [StateCodeW-1:0] RsAutoStart   = 3'd1;
  localparam logic [StateCodeW-1:0] RsAuto        = 3'd2;
  localparam logic [StateCodeW-1:0] RsAutoFinish  = 3'd3;
  localparam logic [StateCodeW-1:0] RsManStart    = 3'd4;
  localparam logic [StateCodeW-1:0] RsMan         = 3'd5;
  localparam logic [StateCodeW-1:0] RsClearing    = 3'd6;

  typedef struct packed {
    logic [FreqW-1:0] motor_freq;
    logic             manual_level;
    logic             manual_trip;
    logic             auto_trip;
  } in_beat_t;

  typedef struct packed {
    logic [StateCodeW-1:0] run_state;
    logic                  motor_enable;
    logic                  start_pulse;
    logic                  stop_pulse;
    logic                  debounce_pulse;
  } out_beat_t;

  typedef struct packed {
    logic [CfgW-1:0] min_safe_freq;
    logic [CfgW-1:0] min_free_freq;
    logic [CfgW-1:0] start_timeout;
    logic [CfgW-1:0] finish_timeout;
  } cfg_t;

  function automatic logic [StateCodeW-1:0] state_code(run_state_e st);
    logic [StateCodeW-1:0] code;
    case (st)
      ST_AUTO_START:  code = RsAutoStart;
      ST_AUTO:        code = RsAuto;
      ST_AUTO_FINISH: code = RsAutoFinish;
      ST_MAN_START:   code = RsManStart;
      ST_MAN:         code = RsMan;
      ST_CLEARING:    code = RsClearing;
      default:        code = RsStopped;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/core/mrs_step.sv -----
module mrs_step import mrs_pkg::*; #(
  parameter int TimerBits = TimerBitsDefault
) (
  input  run_state_e           state_i,
  input  logic [TimerBits-1:0] count_i,
  input  logic                 drive_i,
  input  cfg_t                 cfg_i,
  input  in_beat_t             beat_i,
  output run_state_e           state_o,
  output logic [TimerBits-1:0] count_o,
  output logic                 drive_o,
  output out_beat_t            beat_o
);

  localparam int CmpW = (TimerBits > CfgW) ? TimerBits : CfgW;

  logic [CmpW-1:0] cnt_ext;
  logic            safe, free_run, start_to, finish_to;
  logic            start_p, stop_p, clr;
  run_state_e      nxt;

  assign cnt_ext   = CmpW'(count_i);
  assign safe      = beat_i.motor_freq >= cfg_i.min_safe_freq;
  assign free_run  = beat_i.motor_freq >= cfg_i.min_free_freq;
  assign start_to  = cnt_ext > CmpW'(cfg_i.start_timeout);
  assign finish_to = cnt_ext > CmpW'(cfg_i.finish_timeout);

  always_comb begin
    nxt     = state_i;
    start_p = 1'b0;
    stop_p  = 1'b0;
    clr     = 1'b0;
    case (state_i)
      ST_AUTO_START: begin
        if (safe) begin
          nxt = ST_AUTO;
        end else if (start_to) begin
          nxt    = ST_STOPPED;
          stop_p = 1'b1;
        end
      end
      ST_AUTO: begin
        if (free_run) begin
          nxt = ST_AUTO_FINISH;
          clr = 1'b1;
        end else if (!safe) begin
          nxt    = ST_STOPPED;
          stop_p = 1'b1;
        end else if (beat_i.manual_trip) begin
          nxt = ST_MAN;
        end
      end
      ST_AUTO_FINISH: begin
        if (finish_to) begin
          nxt    = ST_STOPPED;
          stop_p = 1'b1;
        end else if (!free_run) begin
          nxt = ST_AUTO;
        end else if (beat_i.manual_trip) begin
          nxt = ST_MAN;
        end
      end
      ST_MAN_START: begin
        if (safe) begin
          nxt = ST_MAN;
        end else if (start_to || !beat_i.manual_level) begin
          nxt    = ST_STOPPED;
          stop_p = 1'b1;
        end
      end
      ST_MAN: begin
        if (!beat_i.manual_level) begin
          nxt    = ST_STOPPED;
          stop_p = 1'b1;
        end else if (!safe) begin
          nxt    = ST_CLEARING;
          stop_p = 1'b1;
        end
      end
      ST_CLEARING: begin
        if (!beat_i.manual_level) begin
          nxt    = ST_STOPPED;
          stop_p = 1'b1;
        end
      end
      default: begin
        // auto trip wins over manual
        if (beat_i.auto_trip) begin
          nxt     = ST_AUTO_START;
          start_p = 1'b1;
          clr     = 1'b1;
        end else if (beat_i.manual_level) begin
          nxt     = ST_MAN_START;
          start_p = 1'b1;
          clr     = 1'b1;
        end
      end
    endcase
  end

  assign state_o = nxt;
  assign drive_o = start_p | (drive_i & ~stop_p);
  assign count_o = clr ? '0 : ((&count_i) ? count_i : count_i + 1'b1);

  assign beat_o.run_state      = state_code(nxt);
  assign beat_o.motor_enable   = drive_o;
  assign beat_o.start_pulse    = start_p;
  assign beat_o.stop_pulse     = stop_p;
  assign beat_o.debounce_pulse = stop_p & (nxt == ST_STOPPED);

endmodule

// ----- rtl/core/motor_run_supervisor_fsm.sv -----
// channel   direction  handshake                 beat
// in        input      in_valid_i / in_stall_o   in_beat_i  (frequency, switch level, trips)
// out       output     out_valid_o / out_stall_i out_beat_o (state, enable, pulses)
// cfg       input      cfg_we_i                  cfg_addr_i, cfg_wdata_i
//
// one tick per cycle while in_stall_o is low; the result of a tick is registered
// the state update is a single pass from the state registers to the result register
// a skid register behind the result keeps in_stall_o registered, it rises once two
// results wait; reset stops the machine, clears the counter and drive, loads defaults
module motor_run_supervisor_fsm import mrs_pkg::*; #(
  parameter int TimerBits = TimerBitsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_beat_t        in_beat_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_beat_t       out_beat_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_addr_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  cfg_t                 cfg_q;
  run_state_e           state_q, state_d;
  logic [TimerBits-1:0] count_q, count_d;
  logic                 drive_q, drive_d;
  out_beat_t            res, out_q, skid_q;
  logic                 out_valid_q, skid_valid_q;
  logic                 acc, drain;
  logic                 stop_out_ok;

  assign acc   = in_valid_i & ~skid_valid_q;
  assign drain = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_safe_freq  <= MinSafeFreqRst;
      cfg_q.min_free_freq  <= MinFreeFreqRst;
      cfg_q.start_timeout  <= StartTimeoutRst;
      cfg_q.finish_timeout <= FinishTimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_MIN_SAFE_FREQ:  cfg_q.min_safe_freq  <= cfg_wdata_i;
        CFG_MIN_FREE_FREQ:  cfg_q.min_free_freq  <= cfg_wdata_i;
        CFG_START_TIMEOUT:  cfg_q.start_timeout  <= cfg_wdata_i;
        CFG_FINISH_TIMEOUT: cfg_q.finish_timeout <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  mrs_step #(
    .TimerBits(TimerBits)
  ) u_step (
    .state_i(state_q),
    .count_i(count_q),
    .drive_i(drive_q),
    .cfg_i  (cfg_q),
    .beat_i (in_beat_i),
    .state_o(state_d),
    .count_o(count_d),
    .drive_o(drive_d),
    .beat_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_STOPPED;
      count_q <= '0;
      drive_q <= 1'b0;
    end else if (acc) begin
      state_q <= state_d;
      count_q <= count_d;
      drive_q <= drive_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (drain) begin
        skid_valid_q <= 1'b0;
      end
    end else if (acc) begin
      if (!out_valid_q || drain) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (drain) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (drain) begin
        out_q <= skid_q;
      end
    end else if (acc) begin
      if (!out_valid_q || drain) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  assign stop_out_ok = out_q.stop_pulse && (out_q.run_state == RsStopped) && !out_q.motor_enable;

`include "motor_run_supervisor_fsm_assert.svh"

  `MRS_ASSERT(a_skid_behind_out, skid_valid_q, out_valid_q)
  `MRS_ASSERT_NEXT(a_start_drives, acc && res.start_pulse, drive_q)
  `MRS_ASSERT(a_debounce_on_stop, out_valid_q && out_q.debounce_pulse, stop_out_ok)

endmodule
